/* sv/ntc_pkg.sv */
// Shared types and constants for the NTC converter: table geometry,
// range status codes, result and divider interface structs.
// No dependencies.
`default_nettype none

package ntc_pkg;

    localparam int TABLE_ENTRIES = 101;
    localparam int SEARCH_STEPS  = 8;

    localparam int CODE_W   = 12;
    localparam int COUNT_W  = 7;
    localparam int TENTHS_W = 10;
    localparam int STATUS_W = 2;
    // index must also hold TABLE_ENTRIES (initial upper bracket)
    localparam int IDX_W    = $clog2(TABLE_ENTRIES + 1);
    localparam int STEP_W   = (SEARCH_STEPS > 1) ? $clog2(SEARCH_STEPS) : 1;
    localparam int QUOT_W   = 4;
    localparam int NUM_W    = 16;
    localparam int QCNT_W   = 2;

    localparam logic [CODE_W-1:0]  CODE_FIRST    = 12'd3768;
    localparam logic [CODE_W-1:0]  CODE_LAST     = 12'd1327;
    localparam logic [COUNT_W-1:0] SPR_RESET     = 7'd100;
    localparam int                 TENTHS_PER_DEG = 10;

    typedef logic [STATUS_W-1:0] t_status;
    localparam t_status STATUS_IN_RANGE = 2'd0;
    localparam t_status STATUS_COLD     = 2'd1;
    localparam t_status STATUS_HOT      = 2'd2;

    typedef struct packed {
        logic [TENTHS_W-1:0] tenths;
        t_status             status;
        logic [CODE_W-1:0]   code;
    } t_result;

    typedef struct packed {
        logic              start;
        logic [NUM_W-1:0]  num;
        logic [CODE_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } t_div_rsp;

endpackage

`default_nettype wire

/* sv/ntc_rom.sv */
// Descending thermistor code table, one entry per degree, synchronous read.
// Addresses past the table read as zero. Depends on ntc_pkg.
`default_nettype none

module ntc_rom
    import ntc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic [IDX_W-1:0]  i_addr,
    output logic      [CODE_W-1:0] o_data
);

    localparam logic [CODE_W-1:0] CODE_TABLE [TABLE_ENTRIES] = '{
        12'd3768, 12'd3760, 12'd3752, 12'd3744, 12'd3736, 12'd3727, 12'd3718,
        12'd3708, 12'd3698, 12'd3688, 12'd3677, 12'd3666, 12'd3655, 12'd3643,
        12'd3631, 12'd3618, 12'd3605, 12'd3591, 12'd3577, 12'd3563, 12'd3548,
        12'd3532, 12'd3516, 12'd3500, 12'd3483, 12'd3466, 12'd3448, 12'd3430,
        12'd3411, 12'd3392, 12'd3372, 12'd3351, 12'd3330, 12'd3309, 12'd3287,
        12'd3266, 12'd3243, 12'd3219, 12'd3195, 12'd3171, 12'd3146, 12'd3121,
        12'd3095, 12'd3069, 12'd3042, 12'd3015, 12'd2987, 12'd2960, 12'd2931,
        12'd2902, 12'd2873, 12'd2844, 12'd2814, 12'd2784, 12'd2754, 12'd2723,
        12'd2692, 12'd2661, 12'd2629, 12'd2597, 12'd2565, 12'd2533, 12'd2500,
        12'd2468, 12'd2436, 12'd2403, 12'd2370, 12'd2337, 12'd2304, 12'd2271,
        12'd2238, 12'd2205, 12'd2172, 12'd2141, 12'd2108, 12'd2074, 12'd2041,
        12'd2008, 12'd1976, 12'd1944, 12'd1912, 12'd1880, 12'd1848, 12'd1817,
        12'd1785, 12'd1755, 12'd1724, 12'd1693, 12'd1663, 12'd1634, 12'd1604,
        12'd1574, 12'd1546, 12'd1517, 12'd1488, 12'd1460, 12'd1433, 12'd1406,
        12'd1380, 12'd1353, 12'd1327
    };

    logic [CODE_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (int'(i_addr) < TABLE_ENTRIES) begin
            r_data <= CODE_TABLE[i_addr];
        end else begin
            r_data <= '0;
        end
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

/* sv/ntc_div.sv */
// Restoring divider, one quotient bit per cycle, for the interpolation
// fraction. Quotient is known to fit QUOT_W bits. Depends on ntc_pkg.
`default_nettype none

module ntc_div
    import ntc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [QCNT_W-1:0] r_cnt;
    logic [NUM_W-1:0]  r_rem;
    logic [NUM_W-1:0]  r_den_sh;
    logic [QUOT_W-1:0] r_quot;
    logic              w_fit;

    assign w_fit = (r_rem >= r_den_sh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem    <= i_req.num;
            r_den_sh <= NUM_W'(i_req.den) << (QUOT_W - 1);
            r_cnt    <= QCNT_W'(QUOT_W - 1);
            r_quot   <= '0;
        end else if (r_busy) begin
            if (w_fit) begin
                r_rem <= r_rem - r_den_sh;
            end
            r_quot   <= {r_quot[QUOT_W-2:0], w_fit};
            r_den_sh <= r_den_sh >> 1;
            r_cnt    <= r_cnt - QCNT_W'(1);
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

`default_nettype wire

/* sv/ntc_conv.sv */
// Conversion sequencer: range check, binary search over the code ROM,
// then linear interpolation to tenths. Depends on ntc_pkg, ntc_rom, ntc_div.
`default_nettype none

module ntc_conv
    import ntc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [CODE_W-1:0] i_code,
    output logic                   o_busy,
    output logic                   o_res_valid,
    input  wire logic              i_res_take,
    output t_result                o_res
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOOK = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_TOP  = 3'd3;
    localparam logic [2:0] S_BOT  = 3'd4;
    localparam logic [2:0] S_FRAC = 3'd5;
    localparam logic [2:0] S_DIV  = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0]          r_state, n_state;
    logic [CODE_W-1:0]   r_code;
    logic [IDX_W-1:0]    r_lo, n_lo;
    logic [IDX_W-1:0]    r_hi, n_hi;
    logic [IDX_W-1:0]    r_mid;
    logic [STEP_W-1:0]   r_step;
    logic [CODE_W-1:0]   r_top;
    logic [TENTHS_W-1:0] r_tenths;
    t_status             r_status;

    logic [IDX_W-1:0]    w_mid;
    logic [IDX_W-1:0]    w_rom_addr;
    logic [CODE_W-1:0]   w_rom_data;
    logic [TENTHS_W-1:0] w_lo_tenths;
    logic [TENTHS_W-1:0] w_nlo_tenths;
    logic [TENTHS_W-1:0] w_mid_tenths;
    logic                w_frac_ok;
    t_div_req            w_div_req;
    t_div_rsp            w_div_rsp;

    assign w_mid        = r_lo + ((r_hi - r_lo) >> 1);
    assign w_lo_tenths  = TENTHS_W'(r_lo * TENTHS_PER_DEG);
    assign w_nlo_tenths = TENTHS_W'(n_lo * TENTHS_PER_DEG);
    assign w_mid_tenths = TENTHS_W'(r_mid * TENTHS_PER_DEG);
    assign w_frac_ok    = (r_top > w_rom_data) && (r_top >= r_code);

    always_comb begin
        unique case (r_state)
            S_TOP:   w_rom_addr = r_lo;
            S_BOT:   w_rom_addr = r_hi;
            default: w_rom_addr = w_mid;
        endcase
    end

    ntc_rom u_rom (
        .i_clk  (i_clk),
        .i_addr (w_rom_addr),
        .o_data (w_rom_data)
    );

    assign w_div_req.start = (r_state == S_FRAC) && w_frac_ok;
    assign w_div_req.num   = NUM_W'((r_top - r_code) * TENTHS_PER_DEG);
    assign w_div_req.den   = r_top - w_rom_data;

    ntc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // bracket update for the compare step
    always_comb begin
        n_lo = (w_rom_data > r_code) ? r_mid : r_lo;
        n_hi = (w_rom_data < r_code) ? r_mid : r_hi;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_code >= CODE_FIRST || i_code <= CODE_LAST) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_LOOK;
                    end
                end
            end
            S_LOOK: n_state = S_CMP;
            S_CMP: begin
                if (w_rom_data == r_code) begin
                    n_state = S_DONE;
                end else if (n_hi - n_lo == IDX_W'(1)) begin
                    n_state = S_TOP;
                end else if (r_step == STEP_W'(SEARCH_STEPS - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_LOOK;
                end
            end
            S_TOP:  n_state = S_BOT;
            S_BOT:  n_state = S_FRAC;
            S_FRAC: n_state = w_frac_ok ? S_DIV : S_DONE;
            S_DIV:  n_state = w_div_rsp.done ? S_DONE : S_DIV;
            S_DONE: n_state = i_res_take ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_code   <= i_code;
                r_lo     <= '0;
                r_hi     <= IDX_W'(TABLE_ENTRIES);
                r_step   <= '0;
                r_tenths <= '0;
                if (i_code >= CODE_FIRST) begin
                    r_status <= STATUS_COLD;
                end else if (i_code <= CODE_LAST) begin
                    r_status <= STATUS_HOT;
                end else begin
                    r_status <= STATUS_IN_RANGE;
                end
            end
            S_LOOK: r_mid <= w_mid;
            S_CMP: begin
                r_lo   <= n_lo;
                r_hi   <= n_hi;
                r_step <= r_step + STEP_W'(1);
                if (w_rom_data == r_code) begin
                    r_tenths <= w_mid_tenths;
                end else begin
                    // no match: take the lower bracket, which stands when out of steps
                    r_tenths <= w_nlo_tenths;
                end
            end
            S_BOT: r_top <= w_rom_data;
            S_FRAC: r_tenths <= w_lo_tenths;
            S_DIV: begin
                if (w_div_rsp.done) begin
                    r_tenths <= w_lo_tenths + TENTHS_W'(w_div_rsp.quot);
                end
            end
            default: ;
        endcase
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_res_valid  = (r_state == S_DONE);
    assign o_res.tenths = r_tenths;
    assign o_res.status = r_status;
    assign o_res.code   = r_code;

endmodule

`default_nettype wire

/* sv/ntc_adc_to_temperature.sv */
// A sample that completes no period only updates smoothing and counter. A converting
// one passes up to 7 search steps (ROM lookup, compare) and, unless one matches
// exactly, the bracket reads and the bit-serial divider before the output register;
// an out-of-range one goes straight there. Throughput: one sample per cycle between
// conversions; the input stalls while the sequencer is busy. Synchronous active-low
// reset clears smoothing, counter, output valid and loads a period of 100 samples.
`default_nettype none

module ntc_adc_to_temperature
    import ntc_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [CODE_W-1:0]   i_adc_sample,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic      [TENTHS_W-1:0] o_temperature_tenths,
    output logic      [STATUS_W-1:0] o_range_status,
    output logic      [CODE_W-1:0]   o_smoothed_code,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [COUNT_W-1:0]  i_cfg_samples_per_result
);

    logic [CODE_W-1:0]  r_smooth, n_smooth;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [COUNT_W-1:0] r_spr;
    logic               r_out_valid;
    t_result            r_out;

    logic    w_accept;
    logic    w_fire;
    logic    w_busy;
    logic    w_res_valid;
    logic    w_load;
    t_result w_res;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = w_busy;
    assign w_accept    = i_in_valid && !w_busy;

    assign n_smooth = CODE_W'(({1'b0, r_smooth} + {1'b0, i_adc_sample}) >> 1);
    assign n_count  = r_count + COUNT_W'(1);
    assign w_fire   = (n_count == r_spr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smooth <= '0;
            r_count  <= '0;
            r_spr    <= SPR_RESET;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_spr <= i_cfg_samples_per_result;
            end
            if (w_accept) begin
                r_smooth <= n_smooth;
                r_count  <= w_fire ? '0 : n_count;
            end
        end
    end

    ntc_conv u_conv (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_accept && w_fire),
        .i_code      (n_smooth),
        .o_busy      (w_busy),
        .o_res_valid (w_res_valid),
        .i_res_take  (w_load),
        .o_res       (w_res)
    );

    // output register frees the sequencer while a result waits
    assign w_load = w_res_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_temperature_tenths = r_out.tenths;
    assign o_range_status       = r_out.status;
    assign o_smoothed_code      = r_out.code;

endmodule

`default_nettype wire

/* sv/ntc_checker.sv */
// Port-level checks for ntc_adc_to_temperature, attached by bind.
// Depends on ntc_pkg.
`default_nettype none

module ntc_checker
    import ntc_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                o_out_valid,
    input wire logic                i_out_stall,
    input wire logic [TENTHS_W-1:0] o_temperature_tenths,
    input wire logic [STATUS_W-1:0] o_range_status,
    input wire logic [CODE_W-1:0]   o_smoothed_code
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_smoothed_code)
            && $stable(o_temperature_tenths) && $stable(o_range_status))
        else $error("result item changed while stalled");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_range_status != STATUS_IN_RANGE |-> o_temperature_tenths == '0)
        else $error("out of range item carries a temperature");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_range_status == STATUS_COLD && o_smoothed_code >= CODE_FIRST) ||
            (o_range_status == STATUS_HOT && o_smoothed_code <= CODE_LAST) ||
            (o_range_status == STATUS_IN_RANGE && o_smoothed_code < CODE_FIRST
                && o_smoothed_code > CODE_LAST
                && o_temperature_tenths <= TENTHS_W'((TABLE_ENTRIES - 1) * 10)))
        else $error("range status does not match smoothed code");

endmodule

bind ntc_adc_to_temperature ntc_checker u_ntc_checker (.*);

`default_nettype wire
